// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the noise channel.
// Standalone header: no dependencies. Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/ncl_pkg.sv
// Types, constants and helper functions for the noise channel.
// No dependencies.
package ncl_pkg;

	localparam int CYCLE_FIELD_BITS_DEF = 8;
	localparam int TIMER_BITS           = 22;
	localparam int LFSR_BITS            = 15;
	localparam int VOL_BITS             = 4;
	localparam int PACE_BITS            = 3;
	localparam int LEN_BITS             = 7;
	localparam int REQ_BITS             = 2;
	localparam int CFG_INDEX_BITS       = 2;
	localparam int CFG_DATA_BITS        = 8;
	localparam int SHORT_FB_BIT         = 6;
	localparam int PERIOD_BASE_MIN      = 8;

	localparam logic [LEN_BITS-1:0] INIT_LENGTH_RST = LEN_BITS'(64);
	localparam logic [VOL_BITS-1:0] VOL_MAX         = '1;

	typedef enum logic [REQ_BITS-1:0] {
		REQ_TRIGGER  = 2'd0,
		REQ_ADVANCE  = 2'd1,
		REQ_ENV_TICK = 2'd2,
		REQ_LEN_TICK = 2'd3
	} req_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_NOISE_CTRL     = 2'd0,
		CFG_ENVELOPE_CTRL  = 2'd1,
		CFG_LENGTH_ENABLE  = 2'd2,
		CFG_INITIAL_LENGTH = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} fsm_state_t;

	// Period reload: (divider ? divider*16 : 8) << clock shift.
	function automatic logic [TIMER_BITS-1:0] reload_value(input logic [CFG_DATA_BITS-1:0] ctrl);
		logic [2:0]            dv;
		logic [3:0]            sh;
		logic [TIMER_BITS-1:0] base;
		dv   = ctrl[2:0];
		sh   = ctrl[7:4];
		base = (dv != 3'd0) ? TIMER_BITS'({dv, 4'b0000}) : TIMER_BITS'(PERIOD_BASE_MIN);
		return base << sh;
	endfunction

	// One LFSR shift: XNOR of bits 0 and 1 enters the top, and bit 6 in short mode.
	function automatic logic [LFSR_BITS-1:0] lfsr_step(input logic [LFSR_BITS-1:0] s,
			input logic short_mode);
		logic                 fb;
		logic [LFSR_BITS-1:0] r;
		fb = ~(s[0] ^ s[1]);
		r  = {fb, s[LFSR_BITS-1:1]};
		if (short_mode) begin
			r[SHORT_FB_BIT] = fb;
		end
		return r;
	endfunction

endpackage

// File: hdl/noise_channel_lfsr_generator_top.sv
// Noise channel: trigger, cycle advance, envelope and length handling in one block.
// Depends on ncl_pkg and assert_macros.svh.
// Trigger, ticks and zero-cycle advances load their result item into the output register
//   on acceptance; one such item can be accepted every cycle while the output register is empty or being read.
// A nonzero advance works through its window one timer expiry, or the last partial count,
//   at a time in the RUN state, using the single 22-bit timer subtract/compare unit;
//   no item is accepted until it finishes. Reset (arst_n low) clears all state but left_q
//   and the output data registers; initial_length resets to 64.
`include "assert_macros.svh"

module noise_channel_lfsr_generator_top
	import ncl_pkg::*;
#(
	parameter int CYCLE_FIELD_BITS = CYCLE_FIELD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [CFG_DATA_BITS-1:0]    cfg_wdata,

	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [REQ_BITS-1:0]         req_type,
	input  logic [CYCLE_FIELD_BITS-1:0] cycles,

	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [VOL_BITS-1:0]         amplitude,
	output logic                        channel_on,
	output logic [VOL_BITS-1:0]         volume
);

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [CFG_DATA_BITS-1:0] noise_ctrl_q;
	logic [CFG_DATA_BITS-1:0] env_ctrl_q;
	logic                     len_en_q;
	logic [LEN_BITS-1:0]      init_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_ctrl_q <= '0;
			env_ctrl_q   <= '0;
			len_en_q     <= 1'b0;
			init_len_q   <= INIT_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_NOISE_CTRL:     noise_ctrl_q <= cfg_wdata;
				CFG_ENVELOPE_CTRL:  env_ctrl_q   <= cfg_wdata;
				CFG_LENGTH_ENABLE:  len_en_q     <= cfg_wdata[0];
				CFG_INITIAL_LENGTH: init_len_q   <= cfg_wdata[LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Channel state
	// ---------------------------------------------------------------------
	fsm_state_t                  state_q, state_d;
	logic [LFSR_BITS-1:0]        shift_q, shift_d;
	logic [TIMER_BITS-1:0]       timer_q, timer_d;
	logic [VOL_BITS-1:0]         vol_q, vol_d;
	logic [PACE_BITS-1:0]        pace_q, pace_d;
	logic [PACE_BITS-1:0]        cd_q, cd_d;
	logic                        env_up_q, env_up_d;
	logic [LEN_BITS-1:0]         len_left_q, len_left_d;
	logic                        active_q, active_d;
	logic [CYCLE_FIELD_BITS-1:0] left_q, left_d;

	// Output register
	logic                        out_valid_q;
	logic [VOL_BITS-1:0]         amp_q;
	logic                        chan_on_q;
	logic [VOL_BITS-1:0]         vol_out_q;

	logic                        accept;
	logic                        load_out;
	req_t                        req;

	assign accept = in_valid && in_ready;
	assign req    = req_t'(req_type);

	// ---------------------------------------------------------------------
	// Shared timer unit: one expiry (or the final partial count) per cycle.
	// If the remaining count exceeds the timer, consume the timer and expire;
	// otherwise count the timer down by what remains and finish.
	// ---------------------------------------------------------------------
	logic [TIMER_BITS-1:0]       left_wide;
	logic                        left_gt;
	logic [CYCLE_FIELD_BITS-1:0] left_step;
	logic [TIMER_BITS-1:0]       timer_after;
	logic                        expire;
	logic [TIMER_BITS-1:0]       timer_step;
	logic [LFSR_BITS-1:0]        shift_step;
	logic                        run_done;

	always_comb begin
		left_wide = TIMER_BITS'(left_q);
		left_gt   = left_wide > timer_q;
		if (left_gt) begin
			left_step   = left_q - timer_q[CYCLE_FIELD_BITS-1:0];
			timer_after = '0;
		end else begin
			left_step   = '0;
			timer_after = timer_q - left_wide;
		end
		expire     = (timer_after == '0);
		timer_step = expire ? reload_value(noise_ctrl_q) : timer_after;
		shift_step = expire ? lfsr_step(shift_q, noise_ctrl_q[3]) : shift_q;
		run_done   = (left_step == '0);
	end

	// ---------------------------------------------------------------------
	// Sequencer: next state
	// ---------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && req == REQ_ADVANCE && cycles != '0) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (run_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------------
	// Sequencer: outputs. Take a new item only in idle and only when the
	// output register is empty or being emptied this cycle.
	// ---------------------------------------------------------------------
	always_comb begin
		in_ready   = 1'b0;
		out_valid  = out_valid_q;
		amplitude  = amp_q;
		channel_on = chan_on_q;
		volume     = vol_out_q;
		case (state_q)
			ST_IDLE: in_ready = !out_valid_q || out_ready;
			ST_RUN:  in_ready = 1'b0;
			default: in_ready = 1'b0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Channel update
	// ---------------------------------------------------------------------
	always_comb begin
		logic [PACE_BITS-1:0] cd_tmp;
		cd_tmp     = cd_q;
		shift_d    = shift_q;
		timer_d    = timer_q;
		vol_d      = vol_q;
		pace_d     = pace_q;
		cd_d       = cd_q;
		env_up_d   = env_up_q;
		len_left_d = len_left_q;
		active_d   = active_q;
		left_d     = left_q;
		load_out   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req)
						REQ_TRIGGER: begin
							// Restart: clear LFSR, reload timer, latch envelope, reload an empty length, switch on.
							shift_d  = '0;
							timer_d  = reload_value(noise_ctrl_q);
							pace_d   = env_ctrl_q[2:0];
							cd_d     = env_ctrl_q[2:0];
							env_up_d = env_ctrl_q[3];
							vol_d    = env_ctrl_q[7:4];
							if (len_left_q == '0) begin
								len_left_d = init_len_q;
							end
							active_d = 1'b1;
							load_out = 1'b1;
						end
						REQ_ADVANCE: begin
							// A zero count changes nothing and answers at once.
							if (cycles != '0) begin
								left_d = cycles;
							end else begin
								load_out = 1'b1;
							end
						end
						REQ_ENV_TICK: begin
							if (pace_q != '0) begin
								cd_tmp = (cd_q != '0) ? cd_q - PACE_BITS'(1) : cd_q;
								if (cd_tmp == '0) begin
									cd_d = pace_q;
									// Saturate the volume at both ends.
									if (env_up_q && vol_q != VOL_MAX) begin
										vol_d = vol_q + VOL_BITS'(1);
									end else if (!env_up_q && vol_q != '0) begin
										vol_d = vol_q - VOL_BITS'(1);
									end
								end else begin
									cd_d = cd_tmp;
								end
							end
							load_out = 1'b1;
						end
						REQ_LEN_TICK: begin
							// When enabled, count down only while nonzero; switch off on reaching zero.
							if (len_en_q && len_left_q != '0) begin
								len_left_d = len_left_q - LEN_BITS'(1);
								if (len_left_q == LEN_BITS'(1)) begin
									active_d = 1'b0;
								end
							end
							load_out = 1'b1;
						end
						default: load_out = 1'b1;
					endcase
				end
			end
			ST_RUN: begin
				left_d   = left_step;
				timer_d  = timer_step;
				shift_d  = shift_step;
				load_out = run_done;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			shift_q    <= '0;
			timer_q    <= '0;
			vol_q      <= '0;
			pace_q     <= '0;
			cd_q       <= '0;
			env_up_q   <= 1'b0;
			len_left_q <= '0;
			active_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			shift_q    <= shift_d;
			timer_q    <= timer_d;
			vol_q      <= vol_d;
			pace_q     <= pace_d;
			cd_q       <= cd_d;
			env_up_q   <= env_up_d;
			len_left_q <= len_left_d;
			active_q   <= active_d;
		end
	end

	// Remaining cycle count of the advance in progress.
	always_ff @(posedge clk) begin
		left_q <= left_d;
	end

	// ---------------------------------------------------------------------
	// Output register: hold the result item until taken.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			amp_q     <= shift_d[0] ? vol_d : '0;
			chan_on_q <= active_d;
			vol_out_q <= vol_d;
		end
	end

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	`ASSERT_NOW(a_run_not_ready, clk, arst_n, state_q == ST_RUN, !in_ready, "item taken while advancing")
	`ASSERT_NOW(a_run_out_empty, clk, arst_n, state_q == ST_RUN, !out_valid_q, "output busy during advance")
	`ASSERT_NOW(a_run_left_nz, clk, arst_n, state_q == ST_RUN, left_q != '0, "advance running with no cycles left")
	`ASSERT_NEXT(a_trig_timer, clk, arst_n, accept && req == REQ_TRIGGER, timer_q != '0, "trigger left timer at zero")
	`ASSERT_NEXT(a_done_out, clk, arst_n, state_q == ST_RUN && run_done, out_valid_q, "advance finished without result")

endmodule

// File: bench/tb_noise_channel_lfsr_generator_top.sv
// Self-checking bench for noise_channel_lfsr_generator_top: a directed run of the
// corner cases, then phases of random requests under several register settings.
// Depends on ncl_pkg and on the RTL of the block, nothing else.
module tb_noise_channel_lfsr_generator_top
	import ncl_pkg::*;
;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int NUM_PHASES      = 10;
	localparam int LONG_HOLD       = 300;   // receiver hold-off that backs up the block
	localparam int IDLE_LIMIT      = 3000;  // cycles without any handshake before giving up
	localparam int DRAIN_CYCLES    = 40;    // settling time before the final verdict
	localparam int MAX_PRINTED     = 40;

	// One result item of the channel.
	typedef struct packed {
		logic [VOL_BITS-1:0] amplitude;
		logic                channel_on;
		logic [VOL_BITS-1:0] volume;
	} level_t;

	// Tracks the channel state and holds the output levels still owed by the block.
	class noise_level_board;
		logic [CFG_DATA_BITS-1:0] noise_cfg;
		logic [CFG_DATA_BITS-1:0] env_cfg;
		logic                     len_en;
		logic [LEN_BITS-1:0]      init_len;

		logic [LFSR_BITS-1:0]     lfsr;
		logic [TIMER_BITS-1:0]    timer;
		logic [VOL_BITS-1:0]      vol;
		logic [PACE_BITS-1:0]     pace;
		logic [PACE_BITS-1:0]     countdown;
		logic                     up;
		logic [LEN_BITS-1:0]      len_left;
		logic                     active;

		level_t expected_levels[$];

		function new();
			noise_cfg = '0;
			env_cfg   = '0;
			len_en    = 1'b0;
			init_len  = INIT_LENGTH_RST;
			lfsr      = '0;
			timer     = '0;
			vol       = '0;
			pace      = '0;
			countdown = '0;
			up        = 1'b0;
			len_left  = '0;
			active    = 1'b0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] d);
			case (idx)
				CFG_NOISE_CTRL:     noise_cfg = d;
				CFG_ENVELOPE_CTRL:  env_cfg   = d;
				CFG_LENGTH_ENABLE:  len_en    = d[0];
				CFG_INITIAL_LENGTH: init_len  = d[LEN_BITS-1:0];
				default: ;
			endcase
		endfunction

		function logic [TIMER_BITS-1:0] period();
			logic [TIMER_BITS-1:0] base;
			base = (noise_cfg[2:0] != 3'd0) ? TIMER_BITS'({noise_cfg[2:0], 4'b0000})
				: TIMER_BITS'(8);
			return base << noise_cfg[7:4];
		endfunction

		function void clock_lfsr();
			logic fb;
			fb   = ~(lfsr[0] ^ lfsr[1]);
			lfsr = {fb, lfsr[LFSR_BITS-1:1]};
			if (noise_cfg[3]) begin
				lfsr[6] = fb;
			end
		endfunction

		function void run_cycles(logic [7:0] cyc);
			int unsigned left;
			left = 32'(cyc);
			while (left > 0) begin
				if (left > 32'(timer)) begin
					left  = left - 32'(timer);
					timer = '0;
				end else begin
					timer = timer - TIMER_BITS'(left);
					left  = 0;
				end
				if (timer == '0) begin
					timer = period();
					clock_lfsr();
				end
			end
		endfunction

		// Note an accepted request: update the state and queue the level it leads to.
		function void accept_request(req_t r, logic [7:0] cyc);
			level_t e;
			case (r)
				REQ_TRIGGER: begin
					lfsr      = '0;
					timer     = period();
					pace      = env_cfg[2:0];
					countdown = env_cfg[2:0];
					up        = env_cfg[3];
					vol       = env_cfg[7:4];
					if (len_left == '0) begin
						len_left = init_len;
					end
					active = 1'b1;
				end
				REQ_ADVANCE: run_cycles(cyc);
				REQ_ENV_TICK: begin
					if (pace != '0) begin
						if (countdown != '0) begin
							countdown = countdown - 1'b1;
						end
						if (countdown == '0) begin
							countdown = pace;
							if (up && vol != VOL_MAX) begin
								vol = vol + 1'b1;
							end else if (!up && vol != '0) begin
								vol = vol - 1'b1;
							end
						end
					end
				end
				default: begin
					if (len_en && len_left != '0) begin
						len_left = len_left - 1'b1;
						if (len_left == '0) begin
							active = 1'b0;
						end
					end
				end
			endcase
			e.amplitude  = lfsr[0] ? vol : '0;
			e.channel_on = active;
			e.volume     = vol;
			expected_levels.push_back(e);
		endfunction

		// Compare a result against the oldest expected level; empty string when it matches.
		function string compare_level(level_t got);
			level_t e;
			string  msg;
			if (expected_levels.size() == 0) begin
				return $sformatf("unexpected result amp=%0d on=%0d vol=%0d",
					got.amplitude, got.channel_on, got.volume);
			end
			e   = expected_levels.pop_front();
			msg = "";
			if (got.amplitude !== e.amplitude) begin
				msg = {msg, $sformatf(" amplitude got %0d exp %0d", got.amplitude,
					e.amplitude)};
			end
			if (got.channel_on !== e.channel_on) begin
				msg = {msg, $sformatf(" channel_on got %0d exp %0d", got.channel_on,
					e.channel_on)};
			end
			if (got.volume !== e.volume) begin
				msg = {msg, $sformatf(" volume got %0d exp %0d", got.volume,
					e.volume)};
			end
			return msg;
		endfunction

		function int pending();
			return expected_levels.size();
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_we;
	logic [CFG_INDEX_BITS-1:0]   cfg_index;
	logic [CFG_DATA_BITS-1:0]    cfg_wdata;
	logic                        in_valid;
	logic                        in_ready;
	logic [REQ_BITS-1:0]         req_type;
	logic [CYCLE_FIELD_BITS_DEF-1:0] cycles;
	logic                        out_valid;
	logic                        out_ready;
	logic [VOL_BITS-1:0]         amplitude;
	logic                        channel_on;
	logic [VOL_BITS-1:0]         volume;

	noise_level_board board;
	int  errors        = 0;
	int  stall_cycles  = 0;
	int  hold_requests = 0;
	bit  tx_idle_on    = 1'b1;
	bit  rx_idle_on    = 1'b1;

	noise_channel_lfsr_generator_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.cycles     (cycles),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.amplitude  (amplitude),
		.channel_on (channel_on),
		.volume     (volume)
	);

	// 4-unit clock period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Print one line per bad result and count it; cap the printing.
	task automatic report(string what);
		errors++;
		if (errors <= MAX_PRINTED) begin
			$display("mismatch at %0t:%s", $time, what);
		end
	endtask

	// Write one register; called at a falling edge, returns at the next one.
	// The caller lowers cfg_we once the last write of a batch is done.
	task automatic poke_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] d);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = d;
		@(negedge clk);
		board.write_reg(idx, d);
	endtask

	// Load all four registers; only ever called while the channel is idle.
	task automatic set_config(logic [7:0] noise_ctrl, logic [7:0] env_ctrl, logic len_enable,
			logic [6:0] init_length);
		poke_reg(CFG_NOISE_CTRL, noise_ctrl);
		poke_reg(CFG_ENVELOPE_CTRL, env_ctrl);
		poke_reg(CFG_LENGTH_ENABLE, {7'd0, len_enable});
		poke_reg(CFG_INITIAL_LENGTH, {1'b0, init_length});
		cfg_we = 1'b0;
	endtask

	// Offer one request item and hold it until it is taken. Called at a falling edge;
	// returns at the falling edge after acceptance with in_valid still high, so the
	// next item can follow back to back.
	task automatic send_item(req_t r, logic [7:0] c);
		int gap;
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			gap      = $urandom_range(1, 6);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		req_type = r;
		cycles   = c;
		do @(posedge clk); while (!in_ready);
		board.accept_request(r, c);
		@(negedge clk);
	endtask

	// Drop the request line and wait until every expected level has come back.
	task automatic drain();
		in_valid = 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Random request with a bias toward advances; cycle counts favor short
	// windows and the extremes so that expiries land in every position.
	task automatic send_random();
		int   k;
		req_t r;
		logic [7:0] c;
		k = $urandom_range(0, 99);
		if (k < 8) begin
			r = REQ_TRIGGER;
		end else if (k < 55) begin
			r = REQ_ADVANCE;
		end else if (k < 78) begin
			r = REQ_ENV_TICK;
		end else begin
			r = REQ_LEN_TICK;
		end
		k = $urandom_range(0, 9);
		if (k < 5) begin
			c = 8'($urandom_range(0, 255));
		end else if (k < 8) begin
			c = 8'($urandom_range(1, 20));
		end else if (k == 8) begin
			c = 8'd0;
		end else begin
			c = 8'd255;
		end
		send_item(r, c);
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request so that
	// the block fills up and pushes back on its input.
	initial begin : receiver
		int hold_served;
		int n;
		hold_served = 0;
		out_ready   = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_served) begin
				hold_served++;
				out_ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				out_ready = 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				n         = $urandom_range(1, 6);
				out_ready = 1'b0;
				repeat (n) @(negedge clk);
				out_ready = 1'b1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Check every result item taken from the block.
	always @(posedge clk) begin : level_monitor
		level_t got;
		string  why;
		if (arst_n && out_valid && out_ready) begin
			got.amplitude  = amplitude;
			got.channel_on = channel_on;
			got.volume     = volume;
			why = board.compare_level(got);
			if (why != "") begin
				report(why);
			end
		end
	end

	// Give up when neither channel has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int ph;
		int i;
		logic [7:0] nc;
		logic [7:0] ec;
		logic       le;
		logic [6:0] il;

		// Every input known from time zero; reset is held low, then released at a falling edge.
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_NOISE_CTRL;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		req_type  = REQ_TRIGGER;
		cycles    = '0;
		board     = new();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Short mode at the shortest period, volume 15 rising, length counting off.
		set_config(8'h08, 8'hF9, 1'b0, 7'd1);
		send_item(REQ_ADVANCE, 8'd1);       // timer still at zero from reset: expire at once
		send_item(REQ_ADVANCE, 8'd0);       // zero cycles change nothing
		send_item(REQ_ENV_TICK, 8'd0);      // pace still zero: no step
		send_item(REQ_LEN_TICK, 8'd0);      // empty counter and counting off
		send_item(REQ_TRIGGER, 8'hFF);
		send_item(REQ_ADVANCE, 8'd255);     // many expiries with short-mode feedback
		send_item(REQ_ADVANCE, 8'd8);
		send_item(REQ_ENV_TICK, 8'd0);      // volume at 15 holds when rising
		send_item(REQ_LEN_TICK, 8'd0);      // counting off: nothing happens
		send_item(REQ_ADVANCE, 8'd0);
		drain();

		// Falling envelope from zero, length counting on with a counter of one.
		set_config(8'h00, 8'h02, 1'b1, 7'd1);
		send_item(REQ_ENV_TICK, 8'd0);
		send_item(REQ_ENV_TICK, 8'd0);
		send_item(REQ_TRIGGER, 8'd0);       // counter not empty: no reload
		send_item(REQ_ENV_TICK, 8'd0);
		send_item(REQ_ENV_TICK, 8'd0);      // volume at zero holds when falling
		send_item(REQ_LEN_TICK, 8'd0);      // counts to zero: channel off
		send_item(REQ_LEN_TICK, 8'd0);      // empty: no wrap
		drain();

		// Nonzero volume with pace zero so the amplitude shows while the channel is off.
		set_config(8'h01, 8'hA8, 1'b1, 7'd3);
		send_item(REQ_TRIGGER, 8'd0);       // empty counter: reload from initial length
		send_item(REQ_LEN_TICK, 8'd0);
		send_item(REQ_LEN_TICK, 8'd0);
		send_item(REQ_LEN_TICK, 8'd0);      // channel off here
		send_item(REQ_ADVANCE, 8'd255);
		send_item(REQ_ADVANCE, 8'd37);
		send_item(REQ_ENV_TICK, 8'd0);      // pace zero: nothing
		send_item(REQ_ADVANCE, 8'd100);
		drain();

		// Random phases, each opened by a trigger under its own register setting.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin nc = 8'h00; ec = 8'h0F; le = 1'b1; il = 7'd64; end
				1: begin nc = 8'h08; ec = 8'hF1; le = 1'b1; il = 7'd5;  end
				2: begin nc = 8'h17; ec = 8'h8A; le = 1'b0; il = 7'd33; end
				3: begin nc = 8'hFF; ec = 8'hFF; le = 1'b1; il = 7'd64; end
				4: begin nc = 8'h00; ec = 8'h00; le = 1'b0; il = 7'd1;  end
				default: begin
					// keep the clock shift low so that the register actually moves
					nc = {4'($urandom_range(0, 2)), 4'($urandom_range(0, 15))};
					ec = 8'($urandom_range(0, 255));
					le = 1'($urandom_range(0, 1));
					il = 7'($urandom_range(1, 64));
				end
			endcase
			set_config(nc, ec, le, il);
			tx_idle_on = (ph % 4 != 1) && (ph != NUM_PHASES - 1);
			rx_idle_on = (ph % 4 != 3) && (ph != NUM_PHASES - 1);
			send_item(REQ_TRIGGER, 8'($urandom_range(0, 255)));
			for (i = 1; i < ITEMS_PER_PHASE; i++) begin
				if (ph == 2 && i == 20) begin
					hold_requests++;
				end
				send_random();
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: noise_channel_lfsr_generator_top.f
+incdir+hdl
hdl/ncl_pkg.sv
hdl/noise_channel_lfsr_generator_top.sv
bench/tb_noise_channel_lfsr_generator_top.sv
